// ===== rtl/sss_pkg.sv =====
`timescale 1ns / 1ps

package sss_pkg;

  // Width of the rotated vector and of the angle accumulator (degrees * 2^16).
  localparam int unsigned XW = 20;
  localparam int unsigned ZW = 25;
  localparam int unsigned ITERS_PER_STAGE = 4;

  localparam logic signed [15:0] DEG180_Q7 = 16'sd23040;
  localparam logic signed [ZW-1:0] Z_90 = 25'sd5898240;

  localparam logic [1:0] KIND_ALL       = 2'd0;
  localparam logic [1:0] KIND_ID        = 2'd1;
  localparam logic [1:0] KIND_POWER     = 2'd2;
  localparam logic [1:0] KIND_DIRECTION = 2'd3;

  // Sub-mode 0 means latest, highest or nearest; 1 means oldest or lowest.
  localparam logic [1:0] SUB_LATEST  = 2'd0;
  localparam logic [1:0] SUB_OLDEST  = 2'd1;
  localparam logic [1:0] SUB_BETWEEN = 2'd2;

  typedef enum logic [2:0] {
    REG_SELECTION_KIND   = 3'd0,
    REG_SUB_MODE         = 3'd1,
    REG_RANGE_LOW        = 3'd2,
    REG_RANGE_HIGH       = 3'd3,
    REG_TARGET_DIRECTION = 3'd4
  } sss_reg_e;

  typedef struct packed {
    logic [14:0]            source_id;
    logic                   in_map;
    logic signed [15:0]     source_power;
    logic                   last_source;
    logic                   y_zero;
    logic                   x_neg;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [ZW-1:0]   z;
  } sss_pipe_t;

  // Rounded arctangent of 2^-i in degrees scaled by 2^16.
  function automatic logic signed [ZW-1:0] atan_at(input logic [4:0] idx);
    logic signed [ZW-1:0] val;
    unique case (idx)
      5'd0:    val = 25'sd2949120;
      5'd1:    val = 25'sd1740967;
      5'd2:    val = 25'sd919879;
      5'd3:    val = 25'sd466945;
      5'd4:    val = 25'sd234379;
      5'd5:    val = 25'sd117304;
      5'd6:    val = 25'sd58666;
      5'd7:    val = 25'sd29335;
      5'd8:    val = 25'sd14668;
      5'd9:    val = 25'sd7334;
      5'd10:   val = 25'sd3667;
      5'd11:   val = 25'sd1833;
      5'd12:   val = 25'sd917;
      5'd13:   val = 25'sd458;
      5'd14:   val = 25'sd229;
      5'd15:   val = 25'sd115;
      5'd16:   val = 25'sd57;
      5'd17:   val = 25'sd29;
      5'd18:   val = 25'sd14;
      5'd19:   val = 25'sd7;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/sound_source_selector.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// input     in         in_valid_i/in_ready_o   source_id, in_map, source_power,
//                                              x_coord, y_coord, last_source
// output    out        out_valid_o/out_ready_i selected_id, hit, frame_end
// config    in         cfg_we_i                cfg_addr_i, cfg_data_i
//
// One request is accepted per cycle while in_ready_o is high. The angle pipeline has
// ceil(CORDIC_STEPS/4) stages of up to four vectoring steps each, followed by the
// registered output. Reset empties the pipeline, drops the kept candidate and
// sets the configuration registers to their defaults. A stalled output holds the
// pipeline only where stages are full.

module sound_source_selector import sss_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [14:0]        source_id_i,
  input  logic               in_map_i,
  input  logic signed [15:0] source_power_i,
  input  logic signed [15:0] x_coord_i,
  input  logic signed [15:0] y_coord_i,
  input  logic               last_source_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [14:0]        selected_id_o,
  output logic               hit_o,
  output logic               frame_end_o
);

  localparam int unsigned NUM_STAGES = (CORDIC_STEPS + ITERS_PER_STAGE - 1) / ITERS_PER_STAGE;

  logic [1:0]         kind_q;
  logic [1:0]         sub_q;
  logic signed [15:0] range_low_q;
  logic signed [15:0] range_high_q;
  logic signed [15:0] target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q       <= KIND_ID;
      sub_q        <= SUB_LATEST;
      range_low_q  <= '0;
      range_high_q <= '0;
      target_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_SELECTION_KIND:   kind_q       <= cfg_data_i[1:0];
        REG_SUB_MODE:         sub_q        <= cfg_data_i[1:0];
        REG_RANGE_LOW:        range_low_q  <= cfg_data_i;
        REG_RANGE_HIGH:       range_high_q <= cfg_data_i;
        REG_TARGET_DIRECTION: target_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sss_pipe_t           pipe_q [NUM_STAGES+1];
  sss_pipe_t           pipe_d [NUM_STAGES+1];
  logic [NUM_STAGES:0] valid_q;
  logic [NUM_STAGES:0] adv;
  logic                out_free;
  logic                fire;

  assign out_free   = !out_valid_o || out_ready_i;
  assign fire       = valid_q[NUM_STAGES] && out_free;
  assign in_ready_o = adv[0];

  // Vectors in the left half plane are turned by a quarter turn first.
  always_comb begin
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    xs = XW'(x_coord_i);
    ys = XW'(y_coord_i);
    pipe_d[0].source_id    = source_id_i;
    pipe_d[0].in_map       = in_map_i;
    pipe_d[0].source_power = source_power_i;
    pipe_d[0].last_source  = last_source_i;
    pipe_d[0].y_zero       = (y_coord_i == 16'sd0);
    pipe_d[0].x_neg        = x_coord_i[15];
    if (x_coord_i[15]) begin
      if (!y_coord_i[15]) begin
        pipe_d[0].x = ys;
        pipe_d[0].y = -xs;
        pipe_d[0].z = Z_90;
      end else begin
        pipe_d[0].x = -ys;
        pipe_d[0].y = xs;
        pipe_d[0].z = -Z_90;
      end
    end else begin
      pipe_d[0].x = xs;
      pipe_d[0].y = ys;
      pipe_d[0].z = '0;
    end
  end

  for (genvar k = 0; k <= NUM_STAGES; k++) begin : g_pipe
    if (k < NUM_STAGES) begin : g_step
      sss_cordic_stage #(
        .FIRST_STEP  (k * ITERS_PER_STAGE),
        .CORDIC_STEPS(CORDIC_STEPS)
      ) u_stage (
        .stage_i(pipe_q[k]),
        .stage_o(pipe_d[k+1])
      );
      assign adv[k] = !valid_q[k] || adv[k+1];
    end else begin : g_tail
      assign adv[k] = !valid_q[k] || out_free;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv[k]) begin
        if (k == 0) begin
          valid_q[k] <= in_valid_i;
        end else begin
          valid_q[k] <= valid_q[(k == 0) ? 0 : k-1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  sss_pipe_t          last_p;
  logic signed [15:0] angle;
  logic signed [ZW:0] z_round;
  logic signed [ZW:0] z_shift;
  logic signed [16:0] r17;

  assign last_p  = pipe_q[NUM_STAGES];
  assign z_round = (ZW+1)'(last_p.z) + (ZW+1)'(256);
  assign z_shift = z_round >>> 9;
  assign r17     = z_shift[16:0];

  always_comb begin
    if (last_p.y_zero) begin
      angle = last_p.x_neg ? DEG180_Q7 : 16'sd0;
    end else if (r17 > 17'(DEG180_Q7)) begin
      angle = DEG180_Q7;
    end else if (r17 < -17'(DEG180_Q7)) begin
      angle = -DEG180_Q7;
    end else begin
      angle = r17[15:0];
    end
  end

  logic               cand_q;
  logic [14:0]        best_id_q;
  logic signed [15:0] best_power_q;
  logic signed [15:0] best_angle_q;
  logic               cand_d;
  logic [14:0]        best_id_d;
  logic signed [15:0] best_power_d;
  logic signed [15:0] best_angle_d;
  logic               res_valid;
  logic [14:0]        res_id;
  logic               res_hit;
  logic               res_end;

  always_comb begin
    logic               range_mode;
    logic signed [16:0] value;
    logic               match;
    logic signed [16:0] diff_new;
    logic signed [16:0] diff_best;
    logic [16:0]        abs_new;
    logic [16:0]        abs_best;
    range_mode = (kind_q == KIND_ALL) || (sub_q == SUB_BETWEEN);
    case (kind_q)
      KIND_ID:    value = {2'b00, last_p.source_id};
      KIND_POWER: value = 17'(last_p.source_power);
      default:    value = 17'(angle);
    endcase
    match = (kind_q == KIND_ALL) ||
            ((17'(range_low_q) <= value) && (value <= 17'(range_high_q)));
    diff_new  = 17'(angle) - 17'(target_q);
    diff_best = 17'(best_angle_q) - 17'(target_q);
    abs_new   = diff_new[16] ? 17'(-diff_new) : 17'(diff_new);
    abs_best  = diff_best[16] ? 17'(-diff_best) : 17'(diff_best);

    cand_d       = cand_q;
    best_id_d    = best_id_q;
    best_power_d = best_power_q;
    best_angle_d = best_angle_q;
    res_valid    = 1'b0;
    res_id       = '0;
    res_hit      = 1'b0;
    res_end      = 1'b0;

    if (last_p.in_map) begin
      if (range_mode) begin
        if (match) begin
          res_valid = 1'b1;
          res_id    = last_p.source_id;
          res_hit   = 1'b1;
          res_end   = last_p.last_source;
          if (last_p.last_source) begin
            cand_d = 1'b0;
          end
        end
      end else if (!cand_q) begin
        cand_d       = 1'b1;
        best_id_d    = last_p.source_id;
        best_power_d = last_p.source_power;
        best_angle_d = angle;
      end else if (kind_q == KIND_ID) begin
        if ((sub_q == SUB_LATEST && last_p.source_id > best_id_q) ||
            (sub_q == SUB_OLDEST && last_p.source_id < best_id_q)) begin
          best_id_d = last_p.source_id;
        end
      end else if (kind_q == KIND_POWER) begin
        if ((sub_q == SUB_LATEST && last_p.source_power > best_power_q) ||
            (sub_q == SUB_OLDEST && last_p.source_power < best_power_q)) begin
          best_power_d = last_p.source_power;
          best_id_d    = last_p.source_id;
        end
      end else begin
        if (sub_q == SUB_LATEST && abs_new < abs_best) begin
          best_angle_d = angle;
          best_id_d    = last_p.source_id;
        end
      end
    end

    if (last_p.last_source && !res_valid) begin
      res_valid = 1'b1;
      res_end   = 1'b1;
      if (!range_mode && cand_d) begin
        res_id  = best_id_d;
        res_hit = 1'b1;
      end
      cand_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q       <= 1'b0;
      best_id_q    <= '0;
      best_power_q <= '0;
      best_angle_q <= '0;
      out_valid_o  <= 1'b0;
    end else begin
      if (fire) begin
        cand_q       <= cand_d;
        best_id_q    <= best_id_d;
        best_power_q <= best_power_d;
        best_angle_q <= best_angle_d;
      end
      if (fire && res_valid) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      selected_id_o <= res_id;
      hit_o         <= res_hit;
      frame_end_o   <= res_end;
    end
  end

endmodule

// ===== rtl/sss_cordic_stage.sv =====
`timescale 1ns / 1ps

module sss_cordic_stage import sss_pkg::*; #(
  parameter int unsigned FIRST_STEP   = 0,
  parameter int unsigned CORDIC_STEPS = 14
) (
  input  sss_pipe_t stage_i,
  output sss_pipe_t stage_o
);

  always_comb begin
    sss_pipe_t            s;
    logic signed [XW-1:0] xn;
    logic signed [XW-1:0] yn;
    s = stage_i;
    for (int unsigned j = 0; j < ITERS_PER_STAGE; j++) begin
      if (FIRST_STEP + j < CORDIC_STEPS) begin
        if (s.y > 0) begin
          xn  = s.x + (s.y >>> (FIRST_STEP + j));
          yn  = s.y - (s.x >>> (FIRST_STEP + j));
          s.z = s.z + atan_at(5'(FIRST_STEP + j));
        end else begin
          xn  = s.x - (s.y >>> (FIRST_STEP + j));
          yn  = s.y + (s.x >>> (FIRST_STEP + j));
          s.z = s.z - atan_at(5'(FIRST_STEP + j));
        end
        s.x = xn;
        s.y = yn;
      end
    end
    stage_o = s;
  end

endmodule
